>>> rtl/core/kres_pkg.sv
// ----------------------------------------------------------------------------
// kres_pkg
// Shared types and field widths for the keyed record exchange sort unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kres_pkg;

    localparam int unsigned KEY_FIELD_W = 16;
    localparam int unsigned TAG_W       = 6;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] delay_key;
        logic [TAG_W-1:0]       record_tag;
        logic                   is_last;
    } in_item_t;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] sorted_key;
        logic [TAG_W-1:0]       sorted_tag;
        logic                   end_of_set;
    } out_item_t;

endpackage : kres_pkg

`default_nettype wire

>>> rtl/core/keyed_record_exchange_sort_unit.sv
// Loading: one record per cycle is taken while the unit is in its load state;
//   item_stall holds the input back during the sort and the emission.
//   A set of one record skips the sort and goes straight to emission.
// Output: records are emitted one at a time on the single read port of the
//   record memory, and emission waits while the receiver stalls.
// Reset: control state and the record count clear; the record memories keep
//   no reset and need no clearing pass.
// ----------------------------------------------------------------------------
// keyed_record_exchange_sort_unit
// Collects keyed records into an on-chip memory, sorts them in place with an
// exchange sort over one read and one write port, then streams them out in
// ascending key order with the final record flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_exchange_sort_unit #(
    parameter int unsigned MAX_RECORDS = 64,
    parameter int unsigned KEY_BITS    = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire kres_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output kres_pkg::out_item_t      result
);

    import kres_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
    localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_FETCH     = 3'd1;
    localparam logic [2:0] S_PIVOT     = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_STORE     = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_LD   = 3'd6;
    localparam logic [2:0] S_EMIT_HOLD = 3'd7;

    logic [KEY_BITS-1:0] key_mem [MAX_RECORDS];
    logic [TAG_W-1:0]    tag_mem [MAX_RECORDS];

    logic [2:0]          state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [IDX_W-1:0]    n_reg,      n_next;
    logic [IDX_W-1:0]    i_reg,      i_next;
    logic [IDX_W-1:0]    k_reg,      k_next;
    logic [KEY_BITS-1:0] pivot_key_reg, pivot_key_next;
    logic [TAG_W-1:0]    pivot_tag_reg, pivot_tag_next;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [TAG_W-1:0]    rd_tag_reg;
    out_item_t           result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [KEY_BITS-1:0] mem_wkey;
    logic [TAG_W-1:0]    mem_wtag;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    logic [KEY_BITS-1:0]    key_in;
    logic [KEY_FIELD_W-1:0] key_out;
    logic                   accept;
    logic                   has_room;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       last_pos;

    generate
        if (KEY_BITS <= KEY_FIELD_W) begin : g_key_narrow
            assign key_in  = item.delay_key[KEY_BITS-1:0];
            assign key_out = KEY_FIELD_W'(rd_key_reg);
        end
        else begin : g_key_wide
            assign key_in  = KEY_BITS'(item.delay_key);
            assign key_out = rd_key_reg[KEY_FIELD_W-1:0];
        end
    endgenerate

    assign item_stall   = (state_reg != S_LOAD);
    assign accept       = item_valid && !item_stall;
    assign has_room     = (count_reg < CNT_W'(MAX_RECORDS));
    assign count_inc    = count_reg + CNT_W'(1);
    assign last_pos     = count_reg - CNT_W'(1);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        pivot_key_next    = pivot_key_reg;
        pivot_tag_next    = pivot_tag_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        mem_we            = 1'b0;
        mem_waddr         = i_reg;
        mem_wkey          = pivot_key_reg;
        mem_wtag          = pivot_tag_reg;
        mem_re            = 1'b0;
        mem_raddr         = i_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wkey   = key_in;
                        mem_wtag   = item.record_tag;
                        count_next = count_inc;
                    end
                    if (item.is_last)
                    begin
                        k_next = '0;
                        n_next = IDX_W'(1);
                        if (count_next == CNT_W'(1))
                            state_next = S_EMIT_RD;
                        else
                            state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = n_reg;
                state_next = S_PIVOT;
            end
            S_PIVOT:
            begin
                pivot_key_next = rd_key_reg;
                pivot_tag_next = rd_tag_reg;
                mem_re         = 1'b1;
                mem_raddr      = '0;
                i_next         = '0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_key_reg > pivot_key_reg)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = i_reg;
                    pivot_key_next = rd_key_reg;
                    pivot_tag_next = rd_tag_reg;
                end
                if (i_reg == n_reg - IDX_W'(1))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = i_reg + IDX_W'(1);
                    i_next    = i_reg + IDX_W'(1);
                end
            end
            S_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = n_reg;
                if (CNT_W'(n_reg) == last_pos)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = n_reg + IDX_W'(1);
                    n_next     = n_reg + IDX_W'(1);
                    state_next = S_PIVOT;
                end
            end
            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = k_reg;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                result_next.sorted_key = key_out;
                result_next.sorted_tag = rd_tag_reg;
                result_next.end_of_set = (CNT_W'(k_reg) == last_pos);
                result_valid_next      = 1'b1;
                state_next             = S_EMIT_HOLD;
            end
            S_EMIT_HOLD:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (result_reg.end_of_set)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = k_reg + IDX_W'(1);
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pivot_key_reg <= pivot_key_next;
        pivot_tag_reg <= pivot_tag_next;
        result_reg    <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wkey;
            tag_mem[mem_waddr] <= mem_wtag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_key_reg <= key_mem[mem_raddr];
            rd_tag_reg <= tag_mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count above capacity");

    a_result_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_EMIT_HOLD))
        else $error("result valid outside output hold");

    a_end_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.end_of_set)
            |=> (state_reg == S_LOAD && count_reg == '0))
        else $error("final transfer did not return to load");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !has_room && !item.is_last) |=> $stable(count_reg))
        else $error("record count moved on a full store");

    a_scan_below_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (i_reg < n_reg))
        else $error("scan index reached pivot index");

endmodule : keyed_record_exchange_sort_unit

`default_nettype wire

>>> tb/kres_sort_checker.sv
// ----------------------------------------------------------------------------
// kres_sort_checker
// Watches both channels of the sort unit. Every input transfer is loaded into
// a private copy of the record store; a transfer marked last sorts that copy
// with the same exchange order as the unit and queues the records it must
// emit. Every output transfer is compared field by field with the oldest
// queued record. Mismatch and outstanding counts go back to the top.
// ----------------------------------------------------------------------------
module kres_sort_checker
    import kres_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      item_stall,
    input  wire in_item_t  item,
    input  wire logic      result_valid,
    input  wire logic      result_stall,
    input  wire out_item_t result,
    output int             error_count,
    output int             outstanding
);

    localparam int unsigned CAPACITY = 64;

    logic [KEY_FIELD_W-1:0] key_copy [CAPACITY];
    logic [TAG_W-1:0]       tag_copy [CAPACITY];
    int unsigned            held_records;
    int                     errors;
    out_item_t              sorted_records_q [$];

    task automatic sort_and_queue_set();
        logic [KEY_FIELD_W-1:0] k;
        logic [TAG_W-1:0]       t;
        out_item_t              rec;
        for (int n = 0; n < held_records; n++)
        begin
            for (int i = 0; i <= n; i++)
            begin
                if (key_copy[i] > key_copy[n])
                begin
                    k           = key_copy[i];
                    t           = tag_copy[i];
                    key_copy[i] = key_copy[n];
                    tag_copy[i] = tag_copy[n];
                    key_copy[n] = k;
                    tag_copy[n] = t;
                end
            end
        end
        for (int j = 0; j < held_records; j++)
        begin
            rec.sorted_key = key_copy[j];
            rec.sorted_tag = tag_copy[j];
            rec.end_of_set = (j == held_records - 1);
            sorted_records_q.push_back(rec);
        end
        held_records = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            held_records = 0;
            errors       = 0;
            sorted_records_q.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (held_records < CAPACITY)
                begin
                    key_copy[held_records] = item.delay_key;
                    tag_copy[held_records] = item.record_tag;
                    held_records++;
                end
                if (item.is_last)
                    sort_and_queue_set();
            end
            if (result_valid && !result_stall)
            begin
                if (sorted_records_q.size() == 0)
                begin
                    $error("unexpected transfer: sorted_key %h sorted_tag %h end_of_set %b",
                           result.sorted_key, result.sorted_tag, result.end_of_set);
                    errors++;
                end
                else
                begin
                    want = sorted_records_q.pop_front();
                    if (result.sorted_key !== want.sorted_key)
                    begin
                        $error("sorted_key: expected %h, actual %h",
                               want.sorted_key, result.sorted_key);
                        errors++;
                    end
                    if (result.sorted_tag !== want.sorted_tag)
                    begin
                        $error("sorted_tag: expected %h, actual %h",
                               want.sorted_tag, result.sorted_tag);
                        errors++;
                    end
                    if (result.end_of_set !== want.end_of_set)
                    begin
                        $error("end_of_set: expected %b, actual %b",
                               want.end_of_set, result.end_of_set);
                        errors++;
                    end
                end
            end
            error_count <= errors;
            outstanding <= sorted_records_q.size();
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for keyed_record_exchange_sort_unit. A short directed
// run covers key extremes, equal keys and a single-record set; random sets of
// mostly small size follow, with some large and overfull ones so the store
// fills and drops records. The sender works in bursts with gaps, the receiver
// stalls in phases and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import kres_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_START   = 1000;
    localparam int HOLD_LEN     = 2500;
    localparam int DRAIN_CYCLES = 200;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;
    int        error_count;
    int        outstanding;
    int        burst_left;
    int        items_sent;

    keyed_record_exchange_sort_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    kres_sort_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic offer_record(input logic [KEY_FIELD_W-1:0] key,
                                input logic [TAG_W-1:0] tag, input logic last);
        in_item_t rec;
        rec.delay_key  = key;
        rec.record_tag = tag;
        rec.is_last    = last;
        item_valid <= 1'b1;
        item       <= rec;
        do @(posedge clk); while (item_stall);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic offer_random_set(input int size);
        int                     mode;
        logic [KEY_FIELD_W-1:0] key;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < size; k++)
        begin
            case (mode)
                0:       key = KEY_FIELD_W'($urandom_range(0, 3));
                1:       key = $urandom_range(0, 1) ? {KEY_FIELD_W{1'b1}} : '0;
                default: key = KEY_FIELD_W'($urandom);
            endcase
            offer_record(key, TAG_W'($urandom_range(0, 63)), k == size - 1);
        end
    endtask

    initial
    begin
        int sets;
        int size;
        int pick;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        burst_left = 4;
        items_sent = 0;
        sets       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_record(16'hFFFF, 6'h3F, 1'b1);
        offer_record(16'h1234, 6'h01, 1'b0);
        offer_record(16'h0000, 6'h00, 1'b0);
        offer_record(16'hFFFF, 6'h3F, 1'b0);
        offer_record(16'h1234, 6'h02, 1'b0);
        offer_record(16'h8000, 6'h15, 1'b0);
        offer_record(16'h0000, 6'h05, 1'b1);
        offer_record(16'h5555, 6'h0A, 1'b0);
        offer_record(16'h5555, 6'h14, 1'b0);
        offer_record(16'h5555, 6'h1E, 1'b1);
        offer_record(16'h0001, 6'h2A, 1'b0);
        offer_record(16'h0000, 6'h15, 1'b1);
        offer_record(16'hAAAA, 6'h00, 1'b0);
        offer_record(16'h7FFF, 6'h3F, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (sets == 3)
                size = 66;
            else if (pick < 70)
                size = $urandom_range(1, 8);
            else if (pick < 85)
                size = $urandom_range(9, 32);
            else if (pick < 95)
                size = $urandom_range(33, 64);
            else
                size = $urandom_range(65, 72);
            offer_random_set(size);
            sets++;
        end

        item_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int cycles;
        int phase_left;
        int stall_pct;
        result_stall <= 1'b0;
        cycles     = 0;
        phase_left = 0;
        stall_pct  = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            // hold off long enough for the unit to back up its input
            if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_LEN)
                result_stall <= 1'b1;
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

endmodule
